// ===== hdl/rip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants for the Rand index block
// Label and count widths, request and result structs, divider sizing.
// ----------------------------------------------------------------------------
package rip_pkg;

    localparam int LABEL_COUNT = 16;
    localparam int LABEL_W     = $clog2(LABEL_COUNT);
    localparam int CELL_COUNT  = LABEL_COUNT * LABEL_COUNT;
    localparam int CELL_W      = 2 * LABEL_W;
    localparam int MAX_ITEMS   = 65536;
    localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int PAIR_W      = 31;
    localparam int FRAC_W      = 16;
    localparam int IDX_W       = FRAC_W + 1;
    localparam int QUO_W       = IDX_W;
    localparam int ITER_W      = $clog2(QUO_W);
    localparam int DVD_W       = PAIR_W + FRAC_W + 1;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;

    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [CELL_W-1:0]  cell_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [PAIR_W-1:0]  pair_t;
    typedef logic [IDX_W-1:0]   index_t;

    localparam count_t MAX_ITEMS_C = count_t'(MAX_ITEMS);
    localparam index_t INDEX_ONE   = index_t'(1 << FRAC_W);

    typedef struct packed {
        label_t cluster_label;
        label_t class_label;
        logic   last_item;
    } in_item_t;

    typedef struct packed {
        index_t rand_index;
        pair_t  agreeing_pairs;
        pair_t  total_pairs;
        logic   too_few_items;
    } result_t;

    // Finished data set: item count and the three pair sums.
    typedef struct packed {
        count_t n;
        pair_t  same_cluster;
        pair_t  same_class;
        pair_t  same_both;
    } tally_t;

endpackage

// ===== hdl/rand_index_pair_agreement.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rand_index_pair_agreement: streaming Rand index of two labelings
// Counts cluster/class agreement over a data set and reports the index.
// ----------------------------------------------------------------------------
// Each request carries a predicted cluster label, a true class label and a
// last-item mark. Items are counted at one per clock while full is low: the joint
// (cluster, class) count sits in a 256-entry RAM read at accept time and
// updated in the next cycle, with a forwarding register covering back-to-back
// hits on the same cell; per-label counts and the 256 cell valid bits are
// flip-flops, so reset and the end of a data set clear everything at once
// with no clearing pass. On the last item the front end pushes the item
// count and the three pair sums into a two-deep queue and starts the next
// data set immediately; full rises only when a last item meets a full queue.
// The back end evaluates one data set at a time (one multiply for
// n(n-1)/2, one add/subtract for agreeing pairs, one dividend setup, 17
// restoring-divider steps at one quotient bit per cycle, one result load).
// The result is a one-deep output register: empty low means the
// result ports hold a finished data set, taken by pop. Fewer than two items
// give too_few_items with all other fields zero; items past 65536 in one data
// set are ignored.
// ----------------------------------------------------------------------------
module rand_index_pair_agreement (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire rip_pkg::in_item_t item,
    output logic                   empty,
    input  wire logic              pop,
    output rip_pkg::result_t       result
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    rip_pkg::tally_t q_wr_data;
    rip_pkg::tally_t q_rd_data;

    // Counting front end.
    rip_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_data (q_wr_data),
        .q_full (q_full)
    );

    // Finished tallies waiting for evaluation.
    rip_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // Index evaluation and result register.
    rip_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

// ===== hdl/rip_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-old).
// ----------------------------------------------------------------------------
module rip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rip_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_front: item intake and pair counting
// Reads the joint count at accept, updates all counts once the item leaves
// s1, with forwarding, and hands a finished tally to the back end on the last item.
// ----------------------------------------------------------------------------
module rip_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire rip_pkg::in_item_t item,
    output logic                   q_push,
    output rip_pkg::tally_t        q_data,
    input  wire logic              q_full
);

    logic                s1_vld_reg;
    rip_pkg::in_item_t   s1_item_reg;
    rip_pkg::count_t     clu_cnt_reg [rip_pkg::LABEL_COUNT];
    rip_pkg::count_t     cls_cnt_reg [rip_pkg::LABEL_COUNT];
    logic [rip_pkg::CELL_COUNT-1:0] jvalid_reg;
    rip_pkg::count_t     item_count_reg;
    rip_pkg::pair_t      same_cluster_reg;
    rip_pkg::pair_t      same_class_reg;
    rip_pkg::pair_t      same_both_reg;
    logic                fwd_vld_reg;
    rip_pkg::cell_t      fwd_cell_reg;
    rip_pkg::count_t     fwd_val_reg;

    logic                accept;
    logic                advance;
    logic                s1_fire;
    logic                counted;
    rip_pkg::label_t     cl;
    rip_pkg::label_t     cs;
    rip_pkg::cell_t      jcell;
    rip_pkg::count_t     ram_rd_data;
    rip_pkg::count_t     joint_cur;
    logic                wr_en;
    rip_pkg::count_t     joint_next;
    rip_pkg::tally_t     tally_next;

    // A last item waits in s1 only while the request queue is full.
    assign advance = !s1_vld_reg || !(s1_item_reg.last_item && q_full);
    assign full    = !advance;
    assign accept  = push && advance;
    assign s1_fire = s1_vld_reg && advance;

    assign cl      = s1_item_reg.cluster_label;
    assign cs      = s1_item_reg.class_label;
    assign jcell   = {cl, cs};
    assign counted = item_count_reg < rip_pkg::MAX_ITEMS_C;

    rip_ram #(
        .WIDTH (rip_pkg::COUNT_W),
        .DEPTH (rip_pkg::CELL_COUNT)
    ) u_joint_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (jcell),
        .wr_data (joint_next),
        .rd_en   (accept),
        .rd_addr ({item.cluster_label, item.class_label}),
        .rd_data (ram_rd_data)
    );

    // RAM returns old data when the previous item wrote the same cell.
    always_comb
    begin
        if (fwd_vld_reg && (fwd_cell_reg == jcell))
        begin
            joint_cur = fwd_val_reg;
        end
        else if (jvalid_reg[jcell])
        begin
            joint_cur = ram_rd_data;
        end
        else
        begin
            joint_cur = '0;
        end
    end

    assign joint_next = joint_cur + rip_pkg::count_t'(1);
    assign wr_en      = s1_fire && counted && !s1_item_reg.last_item;

    always_comb
    begin
        tally_next.n            = item_count_reg;
        tally_next.same_cluster = same_cluster_reg;
        tally_next.same_class   = same_class_reg;
        tally_next.same_both    = same_both_reg;
        if (counted)
        begin
            tally_next.n            = item_count_reg + rip_pkg::count_t'(1);
            tally_next.same_cluster = same_cluster_reg + rip_pkg::pair_t'(clu_cnt_reg[cl]);
            tally_next.same_class   = same_class_reg + rip_pkg::pair_t'(cls_cnt_reg[cs]);
            tally_next.same_both    = same_both_reg + rip_pkg::pair_t'(joint_cur);
        end
    end

    assign q_push = s1_fire && s1_item_reg.last_item;
    assign q_data = tally_next;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg       <= 1'b0;
            jvalid_reg       <= '0;
            item_count_reg   <= '0;
            same_cluster_reg <= '0;
            same_class_reg   <= '0;
            same_both_reg    <= '0;
            fwd_vld_reg      <= 1'b0;
            fwd_cell_reg     <= '0;
            fwd_val_reg      <= '0;
            for (int i = 0; i < rip_pkg::LABEL_COUNT; i++)
            begin
                clu_cnt_reg[i] <= '0;
                cls_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                s1_vld_reg   <= accept;
                fwd_vld_reg  <= wr_en;
                fwd_cell_reg <= jcell;
                fwd_val_reg  <= joint_next;
            end
            if (s1_fire)
            begin
                if (s1_item_reg.last_item)
                begin
                    jvalid_reg       <= '0;
                    item_count_reg   <= '0;
                    same_cluster_reg <= '0;
                    same_class_reg   <= '0;
                    same_both_reg    <= '0;
                    for (int i = 0; i < rip_pkg::LABEL_COUNT; i++)
                    begin
                        clu_cnt_reg[i] <= '0;
                        cls_cnt_reg[i] <= '0;
                    end
                end
                else if (counted)
                begin
                    jvalid_reg[jcell] <= 1'b1;
                    item_count_reg    <= tally_next.n;
                    same_cluster_reg  <= tally_next.same_cluster;
                    same_class_reg    <= tally_next.same_class;
                    same_both_reg     <= tally_next.same_both;
                    clu_cnt_reg[cl]   <= clu_cnt_reg[cl] + rip_pkg::count_t'(1);
                    cls_cnt_reg[cs]   <= cls_cnt_reg[cs] + rip_pkg::count_t'(1);
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("tally pushed into a full queue");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= rip_pkg::MAX_ITEMS_C)
        else $error("item count past saturation limit");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_item_reg.last_item) |=>
            (item_count_reg == '0) && (jvalid_reg == '0) && !fwd_vld_reg)
        else $error("counts not cleared after last item");
`endif

endmodule
`default_nettype wire

// ===== hdl/rip_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_fifo: short request queue between front and back end
// Holds finished tallies so counting of the next data set keeps going.
// ----------------------------------------------------------------------------
module rip_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire rip_pkg::tally_t wr_data,
    output logic                 q_full,
    input  wire logic            rd_en,
    output rip_pkg::tally_t      rd_data,
    output logic                 q_empty
);

    rip_pkg::tally_t           mem_reg [rip_pkg::Q_DEPTH];
    logic [rip_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [rip_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [rip_pkg::Q_PTR_W:0]   cnt_reg;
    logic                        do_wr;
    logic                        do_rd;

    localparam logic [rip_pkg::Q_PTR_W-1:0] PTR_LAST =
        rip_pkg::Q_PTR_W'(rip_pkg::Q_DEPTH - 1);
    localparam logic [rip_pkg::Q_PTR_W:0] CNT_FULL =
        (rip_pkg::Q_PTR_W + 1)'(rip_pkg::Q_DEPTH);
    localparam logic [rip_pkg::Q_PTR_W:0] CNT_ONE =
        (rip_pkg::Q_PTR_W + 1)'(1);

    assign q_full  = cnt_reg == CNT_FULL;
    assign q_empty = cnt_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CNT_ONE;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CNT_ONE;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rip_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_back: Rand index evaluation
// Total pairs by one multiply, agreeing pairs by add/subtract, then a
// restoring divider producing one quotient bit per cycle into a result reg.
// ----------------------------------------------------------------------------
module rip_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire rip_pkg::tally_t q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output rip_pkg::result_t     result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TOT  = 3'd1;
    localparam logic [2:0] ST_AGR  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam logic [rip_pkg::ITER_W-1:0] ITER_LAST =
        rip_pkg::ITER_W'(rip_pkg::QUO_W - 1);
    localparam logic [rip_pkg::ITER_W-1:0] ITER_ONE =
        rip_pkg::ITER_W'(1);

    logic [2:0]                   st_reg;
    logic [2:0]                   st_next;
    rip_pkg::tally_t              tally_reg;
    rip_pkg::pair_t               total_reg;
    rip_pkg::pair_t               agree_reg;
    rip_pkg::pair_t               rem_reg;
    logic [rip_pkg::QUO_W-1:0]    dvd_reg;
    logic [rip_pkg::ITER_W-1:0]   iter_reg;
    logic                         few_reg;
    rip_pkg::result_t             out_reg;
    logic                         out_vld_reg;

    logic [2*rip_pkg::COUNT_W-1:0] prod;
    rip_pkg::count_t               n_m1;
    logic [rip_pkg::PAIR_W:0]      agree_w;
    logic [rip_pkg::DVD_W-1:0]     dividend;
    logic [rip_pkg::PAIR_W:0]      trial;
    logic [rip_pkg::PAIR_W:0]      trial_sub;
    logic                          ge;
    logic                          out_free;
    logic                          load_out;

    assign n_m1     = tally_reg.n - rip_pkg::count_t'(1);
    assign prod     = tally_reg.n * n_m1;
    assign agree_w  = {1'b0, total_reg} + {tally_reg.same_both, 1'b0}
                      - {1'b0, tally_reg.same_cluster} - {1'b0, tally_reg.same_class};
    // Round to nearest: add half the divisor before dividing.
    assign dividend = {1'b0, agree_reg, {rip_pkg::FRAC_W{1'b0}}}
                      + rip_pkg::DVD_W'(total_reg >> 1);
    assign trial     = {rem_reg, dvd_reg[rip_pkg::QUO_W-1]};
    assign trial_sub = trial - {1'b0, total_reg};
    assign ge        = trial >= {1'b0, total_reg};

    assign out_free = !out_vld_reg || pop;
    assign load_out = (st_reg == ST_FIN) && out_free;
    assign q_pop    = (st_reg == ST_IDLE) && !q_empty;
    assign empty    = !out_vld_reg;
    assign result   = out_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    st_next = ST_TOT;
                end
            end
            ST_TOT:
            begin
                st_next = (tally_reg.n < rip_pkg::count_t'(2)) ? ST_FIN : ST_AGR;
            end
            ST_AGR:  st_next = ST_PREP;
            ST_PREP: st_next = ST_DIV;
            ST_DIV:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    st_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tally_reg <= q_data;
        end
        if (st_reg == ST_TOT)
        begin
            total_reg <= prod[rip_pkg::PAIR_W:1];
            few_reg   <= tally_reg.n < rip_pkg::count_t'(2);
        end
        if (st_reg == ST_AGR)
        begin
            agree_reg <= agree_w[rip_pkg::PAIR_W-1:0];
        end
        if (st_reg == ST_PREP)
        begin
            rem_reg  <= dividend[rip_pkg::DVD_W-1:rip_pkg::QUO_W];
            dvd_reg  <= dividend[rip_pkg::QUO_W-1:0];
            iter_reg <= '0;
        end
        if (st_reg == ST_DIV)
        begin
            rem_reg  <= ge ? trial_sub[rip_pkg::PAIR_W-1:0] : trial[rip_pkg::PAIR_W-1:0];
            dvd_reg  <= {dvd_reg[rip_pkg::QUO_W-2:0], ge};
            iter_reg <= iter_reg + ITER_ONE;
        end
        if (load_out)
        begin
            out_reg.rand_index     <= few_reg ? '0 : dvd_reg;
            out_reg.agreeing_pairs <= few_reg ? '0 : agree_reg;
            out_reg.total_pairs    <= few_reg ? '0 : total_reg;
            out_reg.too_few_items  <= few_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIV) |-> (total_reg != '0))
        else $error("division started with zero divisor");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_FIN && !few_reg) |-> (dvd_reg <= rip_pkg::INDEX_ONE))
        else $error("Rand index above one");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_vld_reg && st_reg == ST_IDLE))
        else $error("finished result not presented");
`endif

endmodule
`default_nettype wire
